// ----- rtl/cbm_pkg.sv -----
// Shared types, constants and helpers for the cartridge bank mapper.
package cbm_pkg;

  // ROM sizes in banks.
  localparam int unsigned PrgBanks8k = 64;
  localparam int unsigned ChrBanks2k = 128;

  // Highest legal bank number in each mapping granularity.
  localparam logic [7:0] PrgMax8k  = 8'(PrgBanks8k - 1);
  localparam logic [7:0] PrgMax16k = 8'(PrgBanks8k / 2 - 1);
  localparam logic [7:0] PrgMax32k = 8'(PrgBanks8k / 4 - 1);
  localparam logic [7:0] ChrMax2k  = 8'(ChrBanks2k - 1);

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam logic        RegDip   = 1'b0;

  // Register write decode, applied to the address under DecMask.
  localparam logic [15:0] DecMask    = 16'h8C17;
  localparam logic [15:0] DecPrg     = 16'h8000;
  localparam logic [15:0] DecMode    = 16'h8400;
  localparam logic [15:0] DecIrqLo   = 16'h8800;
  localparam logic [15:0] DecIrqHi   = 16'h8801;
  localparam logic [15:0] DecBank0   = 16'h8C00;
  localparam logic [15:0] DecBank1   = 16'h8C01;
  localparam logic [15:0] DecBank2   = 16'h8C02;
  localparam logic [15:0] DecBank3   = 16'h8C10;
  localparam logic [15:0] DecBank4   = 16'h8C11;
  localparam logic [15:0] DecBank5   = 16'h8C16;
  localparam logic [15:0] DecBank6   = 16'h8C17;

  // Bus event carried by one input word.
  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdTick  = 2'd2,
    CmdFetch = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  open_bus;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] prg_bank;
    logic [8:0] chr_bank;
    logic       mirror_horizontal;
    logic       irq_line;
  } out_word_t;

  // Mapper register file.
  typedef struct packed {
    logic [7:0]       mode;
    logic [7:0]       prg_sel;
    logic [6:0][7:0]  bank;
    logic [3:0][7:0]  scratch;
    logic             irq_en;
    logic [15:0]      irq_cnt;
    logic             irq_pend;
  } map_state_t;

  // Folds a bank number that exceeds the ROM into range.
  function automatic logic [7:0] limit_bank(logic [7:0] v, logic [7:0] max);
    limit_bank = (v > max) ? (v & max) : v;
  endfunction

endpackage

// ----- rtl/cbm_bank_map.sv -----
// PRG and CHR bank translation from the mapper registers.
module cbm_bank_map import cbm_pkg::*; (
  input  map_state_t  st_i,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] address_i,
  output logic [7:0]  prg_bank_o,
  output logic [8:0]  chr_bank_o
);

  logic [1:0] slot;
  logic [2:0] chr_idx;
  logic [7:0] base;
  logic [7:0] reg_sel;
  logic [7:0] v8k;
  logic [7:0] v16k;
  logic [7:0] v32k;
  logic [7:0] chr_reg;
  logic [7:0] chr_v;
  logic [7:0] prg_map;

  assign slot    = address_i[14:13];
  assign chr_idx = address_i[12:10];

  // 8K mode: three switchable slots plus a fixed last slot.
  always_comb begin
    base = {3'b000, st_i.prg_sel[3], 4'b0000};
    case (slot)
      2'd0:    reg_sel = {4'b0000, st_i.bank[0][3:0]} | base;
      2'd1:    reg_sel = {4'b0000, st_i.bank[1][3:0]} | base;
      2'd2:    reg_sel = {4'b0000, st_i.bank[2][3:0]} | base;
      default: reg_sel = 8'h0F | base;
    endcase
    v8k = limit_bank(reg_sel, PrgMax8k);
  end

  // 32K and 16K modes.
  assign v32k = limit_bank({1'b0, st_i.prg_sel[7:1]}, PrgMax32k);
  assign v16k = slot[1] ? limit_bank(8'hFF, PrgMax16k)
                        : limit_bank(st_i.prg_sel, PrgMax16k);

  always_comb begin
    if (st_i.mode[4]) begin
      prg_map = v8k;
    end else if (st_i.mode[3]) begin
      prg_map = {v32k[5:0], slot};
    end else begin
      prg_map = {v16k[6:0], slot[0]};
    end
  end

  assign prg_bank_o = address_i[15] ? prg_map : 8'h00;

  // CHR uses four 2K windows from bank registers three through six.
  always_comb begin
    case (chr_idx[2:1])
      2'd0:    chr_reg = st_i.bank[3];
      2'd1:    chr_reg = st_i.bank[4];
      2'd2:    chr_reg = st_i.bank[5];
      default: chr_reg = st_i.bank[6];
    endcase
    chr_v = limit_bank(chr_reg, ChrMax2k);
  end

  assign chr_bank_o = (cmd_i == CmdFetch) ? {chr_v, chr_idx[0]} : 9'h000;

endmodule

// ----- rtl/cartridge_bank_mapper_irq.sv -----
// Top level of the cartridge bank mapper with its cycle-driven IRQ counter.
// The block takes one bus word (CPU write, CPU read, CPU cycle tick or PPU
// pattern fetch) per clock while the output side keeps taking results, and
// returns one result word for each, reflecting the mapper state after that
// word. A word is held in the input register, where the register update and
// bank translation are worked out, and then moves into the result register
// once that register is empty or being drained. The DIP switch bits are set
// through the APB port at offset 0.
module cartridge_bank_mapper_irq import cbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic       s1_valid_q;
  in_word_t   s1_word_q;
  logic       out_valid_q;
  out_word_t  out_word_q;
  out_word_t  out_word_d;
  map_state_t st_q;
  map_state_t st_d;
  logic [1:0] dip_q;
  logic       out_free;
  logic       advance;
  logic [15:0] addr;
  logic [15:0] cnt_dec;
  logic        in_scratch;
  logic        in_dip;
  logic [7:0]  rd_data;
  logic [7:0]  prg_bank;
  logic [8:0]  chr_bank;

  // Configuration port: DIP switch register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDip) ? {30'd0, dip_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q <= 2'b11;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegDip)) begin
      dip_q <= pwdata[1:0];
    end
  end

  // Pipeline handshake: the input register moves on when the result
  // register is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  // Address ranges for the scratch bytes and DIP reads.
  assign addr       = s1_word_q.address;
  assign in_scratch = (addr[15:12] == 4'h5) && (addr[11:10] != 2'b00);
  assign in_dip     = (addr[15:10] == 6'b010100);

  // Register update and read data for the word in the input register.
  always_comb begin
    st_d    = st_q;
    rd_data = 8'h00;
    cnt_dec = st_q.irq_cnt - 16'd1;
    case (s1_word_q.cmd)
      CmdWrite: begin
        if (in_scratch) begin
          st_d.scratch[addr[1:0]] = s1_word_q.data;
        end else begin
          case (addr & DecMask)
            DecPrg:   st_d.prg_sel = s1_word_q.data;
            DecMode:  st_d.mode = s1_word_q.data;
            DecIrqLo: begin
              st_d.irq_cnt[7:0] = s1_word_q.data;
              st_d.irq_pend     = 1'b0;
            end
            DecIrqHi: begin
              st_d.irq_cnt[15:8] = s1_word_q.data;
              st_d.irq_en        = st_q.mode[7];
            end
            DecBank0: st_d.bank[0] = s1_word_q.data;
            DecBank1: st_d.bank[1] = s1_word_q.data;
            DecBank2: st_d.bank[2] = s1_word_q.data;
            DecBank3: st_d.bank[3] = s1_word_q.data;
            DecBank4: st_d.bank[4] = s1_word_q.data;
            DecBank5: st_d.bank[5] = s1_word_q.data;
            DecBank6: st_d.bank[6] = s1_word_q.data;
            default:  ;
          endcase
        end
      end
      CmdRead: begin
        if (in_dip) begin
          rd_data = {s1_word_q.open_bus[7:2], dip_q};
        end else if (in_scratch) begin
          rd_data = st_q.scratch[addr[1:0]];
        end else begin
          rd_data = s1_word_q.open_bus;
        end
      end
      CmdTick: begin
        // Armed counter counts down; reaching zero raises the IRQ and disarms.
        if (st_q.irq_en) begin
          if (cnt_dec == 16'h0000) begin
            st_d.irq_pend = 1'b1;
            st_d.irq_en   = 1'b0;
            st_d.irq_cnt  = 16'hFFFF;
          end else begin
            st_d.irq_cnt = cnt_dec;
          end
        end
      end
      default: ;
    endcase
  end

  // Bank translation uses the state after this word.
  cbm_bank_map u_bank_map (
    .st_i       (st_d),
    .cmd_i      (s1_word_q.cmd),
    .address_i  (addr),
    .prg_bank_o (prg_bank),
    .chr_bank_o (chr_bank)
  );

  always_comb begin
    out_word_d.read_data         = rd_data;
    out_word_d.prg_bank          = prg_bank;
    out_word_d.chr_bank          = chr_bank;
    out_word_d.mirror_horizontal = st_d.mode[0];
    out_word_d.irq_line          = st_d.irq_pend;
  end

  // Mapper state commits when the word moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
